/* hdl/fpsa_pkg.sv */
// ----------------------------------------------------------------------------
// fpsa_pkg: shared types and constants for the free page stack allocator
// Word layouts for both channels, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package fpsa_pkg;

    // fixed field widths of the channel words
    localparam int FRAME_W = 52;
    localparam int TYPE_W  = 32;
    localparam int PAGES_W = 32;
    localparam int COUNT_W = 13;

    // defaults for the top level parameters
    localparam int STORE_DEPTH_DEF = 4096;
    localparam int FRAME_BITS_DEF  = 52;

    // register reset and count ceiling
    localparam logic [TYPE_W-1:0]  USABLE_RESET = 32'd7;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 13'd8191;

    // operation codes
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;
    localparam logic [1:0] OP_FREE    = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_EMPTY      = 2'd1;
    localparam logic [1:0] STAT_FULL       = 2'd2;
    localparam logic [1:0] STAT_NOT_USABLE = 2'd3;

    // input word
    typedef struct packed {
        logic [1:0]         op;
        logic [TYPE_W-1:0]  region_type;
        logic [FRAME_W-1:0] region_start_frame;
        logic [PAGES_W-1:0] region_pages;
        logic [FRAME_W-1:0] freed_frame;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] granted_frame;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] page_total;
    } out_word_t;

endpackage

/* hdl/free_page_stack_allocator_core.sv */
// ----------------------------------------------------------------------------
// free_page_stack_allocator_core: last-in-first-out page frame allocator
// Free frames live in a stack held in one RAM; requests pop, frees and
// region adds push, every input word gives one result word.
//
//   channel   direction  ports                     content
//   s_        in         s_valid s_ready s_data    operation word
//   m_        out        m_valid m_ready m_data    status, frame and counts
//   cfg_      in         cfg_wr_en cfg_wr_data     usable region type
//
// Clear, free, an empty request and a region that pushes nothing are answered
// from the idle state; a request waits in ST_READ for the RAM read; add region
// pushes its pages in ST_FILL, with a full status if the store fills first.
// A result that cannot leave because the output register is full waits in
// a holding register; no new word is taken until it moves on.
// Reset is synchronous and clears the stack pointer, not the RAM contents.
// ----------------------------------------------------------------------------
module free_page_stack_allocator_core #(
    parameter int STORE_DEPTH = fpsa_pkg::STORE_DEPTH_DEF,
    parameter int FRAME_BITS  = fpsa_pkg::FRAME_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fpsa_pkg::in_word_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fpsa_pkg::out_word_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [fpsa_pkg::TYPE_W-1:0]   cfg_wr_data
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int TOP_W  = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W  = (TOP_W > fpsa_pkg::COUNT_W) ? TOP_W : fpsa_pkg::COUNT_W;
    localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(STORE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_FILL = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    logic [TOP_W-1:0]                  top_reg, top_next;
    logic [fpsa_pkg::COUNT_W-1:0]      acc_reg, acc_next;
    logic [FRAME_BITS-1:0]             cur_reg, cur_next;
    logic [fpsa_pkg::PAGES_W-1:0]      rem_reg, rem_next;
    logic [fpsa_pkg::TYPE_W-1:0]       usable_reg;
    fpsa_pkg::out_word_t               pend_reg;
    fpsa_pkg::out_word_t               out_reg;
    logic                              out_valid_reg;

    logic                              mem_we;
    logic [ADDR_W-1:0]                 mem_waddr;
    logic [FRAME_BITS-1:0]             mem_wdata;
    logic [ADDR_W-1:0]                 mem_raddr;
    logic [FRAME_BITS-1:0]             mem_rdata;

    logic                              res_valid;
    logic [1:0]                        res_status;
    logic [FRAME_BITS-1:0]             res_granted;
    fpsa_pkg::out_word_t               res;
    logic                              out_free;
    logic                              top_full;
    logic [CMP_W-1:0]                  top_ext;

    // free stack storage
    fpsa_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign top_full = (top_reg == TOP_FULL);
    assign s_ready  = (state_reg == ST_IDLE);

    // sequencer: stack update, RAM access and result production
    always_comb begin
        state_next  = state_reg;
        top_next    = top_reg;
        acc_next    = acc_reg;
        cur_next    = cur_reg;
        rem_next    = rem_reg;
        mem_we      = 1'b0;
        mem_waddr   = top_reg[ADDR_W-1:0];
        mem_wdata   = cur_reg;
        mem_raddr   = ADDR_W'(top_reg - TOP_W'(1));
        res_valid   = 1'b0;
        res_status  = fpsa_pkg::STAT_OK;
        res_granted = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.op)
                        fpsa_pkg::OP_CLEAR: begin
                            top_next  = '0;
                            acc_next  = '0;
                            res_valid = 1'b1;
                        end
                        fpsa_pkg::OP_ADD: begin
                            if (s_data.region_type != usable_reg) begin
                                res_status = fpsa_pkg::STAT_NOT_USABLE;
                                res_valid  = 1'b1;
                            end else if (s_data.region_pages == '0) begin
                                res_valid = 1'b1;
                            end else begin
                                cur_next   = s_data.region_start_frame[FRAME_BITS-1:0];
                                rem_next   = s_data.region_pages;
                                state_next = ST_FILL;
                            end
                        end
                        fpsa_pkg::OP_REQUEST: begin
                            if (top_reg == '0) begin
                                res_status = fpsa_pkg::STAT_EMPTY;
                                res_valid  = 1'b1;
                            end else begin
                                // read of the top entry is issued this edge
                                top_next   = top_reg - TOP_W'(1);
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            if (top_full) begin
                                res_status = fpsa_pkg::STAT_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = s_data.freed_frame[FRAME_BITS-1:0];
                                top_next  = top_reg + TOP_W'(1);
                            end
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_granted = mem_rdata;
                res_valid   = 1'b1;
            end
            ST_FILL: begin
                if (top_full) begin
                    res_status = fpsa_pkg::STAT_FULL;
                    res_valid  = 1'b1;
                end else begin
                    // push one page of the region per cycle
                    mem_we   = 1'b1;
                    top_next = top_reg + TOP_W'(1);
                    acc_next = (acc_reg == fpsa_pkg::COUNT_MAX)
                               ? acc_reg
                               : acc_reg + fpsa_pkg::COUNT_W'(1);
                    cur_next = cur_reg + FRAME_BITS'(1);
                    rem_next = rem_reg - fpsa_pkg::PAGES_W'(1);
                    if (rem_reg == fpsa_pkg::PAGES_W'(1)) begin
                        res_valid = 1'b1;
                    end
                end
            end
            ST_HOLD: begin
                res_valid = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (res_valid) begin
            state_next = out_free ? ST_IDLE : ST_HOLD;
        end
    end

    // result word, counts taken after this step's update
    assign top_ext = CMP_W'(top_next);

    always_comb begin
        if (state_reg == ST_HOLD) begin
            res = pend_reg;
        end else begin
            res.status        = res_status;
            res.granted_frame = fpsa_pkg::FRAME_W'(res_granted);
            res.free_count    = (top_ext > CMP_W'(fpsa_pkg::COUNT_MAX))
                                ? fpsa_pkg::COUNT_MAX
                                : top_ext[fpsa_pkg::COUNT_W-1:0];
            res.page_total    = acc_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            acc_reg   <= acc_next;
            if (res_valid && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // usable type register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usable_reg <= fpsa_pkg::USABLE_RESET;
        end else if (cfg_wr_en) begin
            usable_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        rem_reg <= rem_next;
        if (res_valid && out_free) begin
            out_reg <= res;
        end
        if (res_valid && !out_free) begin
            pend_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    // stack pointer never passes the store depth
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= TOP_FULL)
        else $error("stack pointer beyond store depth");

    // no push into a full store
    a_no_full_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !top_full)
        else $error("write into full store");

    // a request on a non-empty store waits for the RAM read
    a_req_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.op == fpsa_pkg::OP_REQUEST && top_reg != '0)
        |=> (state_reg == ST_READ && top_reg == $past(top_reg) - TOP_W'(1)))
        else $error("request did not pop the stack");

    // a result waiting in the holding register leaves before any new word
    a_hold_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> !s_ready)
        else $error("input taken while result held");
`endif

endmodule

/* hdl/fpsa_ram.sv */
// ----------------------------------------------------------------------------
// fpsa_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fpsa_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
